/* rtl/mvna_pkg.sv */
// Shared types, constants and helper functions for the mesh vertex normal accumulator.
// No dependencies; every other file in rtl/ except mvna_queue refers to this package by scoped names.
package mvna_pkg;

  localparam int IDX_W = 10;
  localparam int REQ_W = 2;
  localparam int NRM_W = 16;
  localparam int ACC_W = 64;
  localparam int OP_W  = 2;

  localparam logic [NRM_W-1:0] NRM_SAT = 16'd32767;
  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Request codes as they arrive on the input channel.
  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD = 2'd0,
    REQ_FACE = 2'd1,
    REQ_READ = 2'd2
  } req_t;

  // Operations after classification; READZ is a read of an out-of-range vertex.
  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_FACE  = 2'd1,
    OP_READ  = 2'd2,
    OP_READZ = 2'd3
  } op_t;

  // Result of the normalization unit.
  typedef struct packed {
    logic                    degen;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
  } nrm_res_t;

  // Signed 64-bit add that clamps at the two's complement limits.
  function automatic logic [ACC_W-1:0] sat_add64(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
    logic [ACC_W-1:0] s;
    s = a + b;
    if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
      s = a[ACC_W-1] ? ACC_MIN : ACC_MAX;
    end
    return s;
  endfunction

endpackage

/* rtl/mvna_front.sv */
// Front end of the mesh vertex normal accumulator: accepts items and classifies them.
// Depends on mvna_pkg; feeds mvna_queue with a packed operation word.
module mvna_front #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_BITS   = 24,
  localparam int QW = mvna_pkg::OP_W + 3 * mvna_pkg::IDX_W + 3 * COORD_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mvna_pkg::REQ_W-1:0]     in_req_type,
  input  logic [mvna_pkg::IDX_W-1:0]     in_index_a,
  input  logic [mvna_pkg::IDX_W-1:0]     in_index_b,
  input  logic [mvna_pkg::IDX_W-1:0]     in_index_c,
  input  logic signed [COORD_BITS-1:0]   in_pos_x,
  input  logic signed [COORD_BITS-1:0]   in_pos_y,
  input  logic signed [COORD_BITS-1:0]   in_pos_z,
  output logic                           q_valid,
  input  logic                           q_ready,
  output logic [QW-1:0]                  q_data
);

  logic            v_r, v_nxt;
  logic [QW-1:0]   d_r;
  logic            take, keep;
  logic            a_ok, b_ok, c_ok;
  mvna_pkg::op_t   op;

  assign a_ok = 32'(in_index_a) < MAX_VERTICES;
  assign b_ok = 32'(in_index_b) < MAX_VERTICES;
  assign c_ok = 32'(in_index_c) < MAX_VERTICES;

  // Items that would change nothing and return nothing are dropped here.
  always_comb begin
    keep = 1'b0;
    op   = mvna_pkg::OP_LOAD;
    unique case (mvna_pkg::req_t'(in_req_type))
      mvna_pkg::REQ_LOAD: begin
        op   = mvna_pkg::OP_LOAD;
        keep = a_ok;
      end
      mvna_pkg::REQ_FACE: begin
        op   = mvna_pkg::OP_FACE;
        keep = a_ok & b_ok & c_ok;
      end
      mvna_pkg::REQ_READ: begin
        op   = a_ok ? mvna_pkg::OP_READ : mvna_pkg::OP_READZ;
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready = en & (~v_r | q_ready);
  assign take     = in_valid & in_ready;
  assign q_valid  = v_r;
  assign q_data   = d_r;

  always_comb begin
    if (take) begin
      v_nxt = keep;
    end else if (q_ready) begin
      v_nxt = 1'b0;
    end else begin
      v_nxt = v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      d_r <= {op, in_index_a, in_index_b, in_index_c, in_pos_z, in_pos_y, in_pos_x};
    end
  end

endmodule

/* rtl/mvna_queue.sv */
// Two-entry queue between the front end and the back end.
// No package dependency; the payload is an opaque word of width W.
module mvna_queue #(
  parameter int W = 104
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic [W-1:0] buf_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         push, pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = buf_r[rp_r];
  assign push      = in_valid & in_ready;
  assign pop       = out_valid & out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= in_data;
    end
  end

endmodule

/* rtl/mvna_norm.sv */
// Iterative normalization unit: scales a 64-bit vector sum to a Q1.15 unit vector.
// Depends on mvna_pkg; one bit of shift, root or quotient is resolved per cycle.
module mvna_norm (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [mvna_pkg::ACC_W-1:0]        sx,
  input  logic [mvna_pkg::ACC_W-1:0]        sy,
  input  logic [mvna_pkg::ACC_W-1:0]        sz,
  output logic                              done,
  output mvna_pkg::nrm_res_t                res
);

  localparam int AW = mvna_pkg::ACC_W;
  localparam int RW = 47;

  typedef enum logic [7:0] {
    N_IDLE  = 8'b0000_0001,
    N_MAX   = 8'b0000_0010,
    N_SHIFT = 8'b0000_0100,
    N_SQ    = 8'b0000_1000,
    N_ROOT  = 8'b0001_0000,
    N_DINIT = 8'b0010_0000,
    N_DIV   = 8'b0100_0000,
    N_DONE  = 8'b1000_0000
  } nst_t;

  nst_t                                st_r;
  logic [AW-1:0]                       a_r [3];
  logic [2:0]                          neg_r;
  logic [AW-1:0]                       m_r;
  logic [4:0]                          cnt_r;
  logic [59:0]                         prod_r;
  logic [AW-1:0]                       sq_r;
  logic [AW-1:0]                       rs_r, res_r, bit_r;
  logic [RW-1:0]                       rem_r, dv_r;
  logic [mvna_pkg::NRM_W-1:0]          q_r;
  logic [1:0]                          comp_r;
  logic signed [mvna_pkg::NRM_W-1:0]   n_r [3];
  logic                                degen_r;

  logic [AW-1:0]                       m_max, rt;
  logic [mvna_pkg::NRM_W-1:0]          q_new, q_sat;
  logic                                ge;

  function automatic logic [AW-1:0] mag(input logic [AW-1:0] v);
    return v[AW-1] ? (~v + 64'd1) : v;
  endfunction

  always_comb begin
    m_max = a_r[0];
    if (a_r[1] > m_max) begin
      m_max = a_r[1];
    end
    if (a_r[2] > m_max) begin
      m_max = a_r[2];
    end
  end

  assign rt    = res_r + bit_r;
  assign ge    = rem_r >= dv_r;
  assign q_new = {q_r[mvna_pkg::NRM_W-2:0], ge};
  assign q_sat = (q_new > mvna_pkg::NRM_SAT) ? mvna_pkg::NRM_SAT : q_new;

  assign done      = (st_r == N_DONE);
  assign res.degen = degen_r;
  assign res.nx    = n_r[0];
  assign res.ny    = n_r[1];
  assign res.nz    = n_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= N_IDLE;
    end else begin
      unique case (st_r)
        N_IDLE: begin
          if (start) begin
            st_r <= N_MAX;
          end
        end
        N_MAX: begin
          st_r <= (m_max == '0) ? N_DONE : N_SHIFT;
        end
        N_SHIFT: begin
          if ((m_r[AW-1:30] == '0) && m_r[29]) begin
            st_r <= N_SQ;
          end
        end
        N_SQ: begin
          if (cnt_r[1:0] == 2'd3) begin
            st_r <= N_ROOT;
          end
        end
        N_ROOT: begin
          if (cnt_r == 5'd31) begin
            st_r <= N_DINIT;
          end
        end
        N_DINIT: begin
          st_r <= N_DIV;
        end
        N_DIV: begin
          if (cnt_r == 5'd15) begin
            st_r <= (comp_r == 2'd2) ? N_DONE : N_DINIT;
          end
        end
        N_DONE: begin
          st_r <= N_IDLE;
        end
        default: begin
          st_r <= N_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      N_IDLE: begin
        if (start) begin
          a_r[0]  <= mag(sx);
          a_r[1]  <= mag(sy);
          a_r[2]  <= mag(sz);
          neg_r   <= {sz[AW-1], sy[AW-1], sx[AW-1]};
          degen_r <= 1'b0;
        end
      end
      N_MAX: begin
        m_r <= m_max;
        if (m_max == '0) begin
          degen_r <= 1'b1;
          n_r[0]  <= '0;
          n_r[1]  <= '0;
          n_r[2]  <= '0;
        end
      end
      N_SHIFT: begin
        // Move the top set bit of the largest magnitude onto bit 29.
        if (m_r[AW-1:30] != '0) begin
          m_r <= m_r >> 1;
          for (int i = 0; i < 3; i++) begin
            a_r[i] <= a_r[i] >> 1;
          end
        end else if (!m_r[29]) begin
          m_r <= m_r << 1;
          for (int i = 0; i < 3; i++) begin
            a_r[i] <= a_r[i] << 1;
          end
        end else begin
          cnt_r <= '0;
          sq_r  <= '0;
        end
      end
      N_SQ: begin
        if (cnt_r[1:0] != 2'd3) begin
          prod_r <= a_r[cnt_r[1:0]][29:0] * a_r[cnt_r[1:0]][29:0];
        end
        if (cnt_r[1:0] != 2'd0) begin
          sq_r <= sq_r + 64'(prod_r);
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r[1:0] == 2'd3) begin
          rs_r  <= sq_r + 64'(prod_r);
          res_r <= '0;
          bit_r <= 64'd1 << 62;
          cnt_r <= '0;
        end
      end
      N_ROOT: begin
        if (rs_r >= rt) begin
          rs_r  <= rs_r - rt;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r  <= bit_r >> 2;
        cnt_r  <= cnt_r + 5'd1;
        comp_r <= '0;
      end
      N_DINIT: begin
        rem_r <= {2'b00, a_r[comp_r][29:0], 15'd0} + RW'(res_r[31:1]);
        dv_r  <= {res_r[31:0], 15'd0};
        q_r   <= '0;
        cnt_r <= '0;
      end
      N_DIV: begin
        if (ge) begin
          rem_r <= rem_r - dv_r;
        end
        dv_r  <= dv_r >> 1;
        q_r   <= q_new;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd15) begin
          n_r[comp_r] <= neg_r[comp_r] ? -$signed(q_sat) : $signed(q_sat);
          comp_r      <= comp_r + 2'd1;
        end
      end
      N_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/mvna_back.sv */
// Back end: position and accumulator memories, face sequencer and result register.
// Depends on mvna_pkg; drives mvna_norm for reads and takes items from mvna_queue.
module mvna_back #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_BITS   = 24,
  localparam int QW = mvna_pkg::OP_W + 3 * mvna_pkg::IDX_W + 3 * COORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  output logic                              clr_done,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  logic [QW-1:0]                     q_data,
  output logic                              norm_start,
  output logic [mvna_pkg::ACC_W-1:0]        norm_sx,
  output logic [mvna_pkg::ACC_W-1:0]        norm_sy,
  output logic [mvna_pkg::ACC_W-1:0]        norm_sz,
  input  logic                              norm_done,
  input  mvna_pkg::nrm_res_t                norm_res,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mvna_pkg::IDX_W-1:0]        out_vertex_index,
  output logic signed [mvna_pkg::NRM_W-1:0] out_normal_x,
  output logic signed [mvna_pkg::NRM_W-1:0] out_normal_y,
  output logic signed [mvna_pkg::NRM_W-1:0] out_normal_z,
  output logic                              out_degenerate
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int XW = PW + 1;
  localparam int IW = mvna_pkg::IDX_W;
  localparam int SW = mvna_pkg::ACC_W;

  typedef enum logic [8:0] {
    B_CLEAR  = 9'b0_0000_0001,
    B_IDLE   = 9'b0_0000_0010,
    B_FPOS   = 9'b0_0000_0100,
    B_FDIFF  = 9'b0_0000_1000,
    B_FMUL   = 9'b0_0001_0000,
    B_FACC   = 9'b0_0010_0000,
    B_RSTART = 9'b0_0100_0000,
    B_RNORM  = 9'b0_1000_0000,
    B_ROUT   = 9'b1_0000_0000
  } bst_t;

  bst_t                   st_r;
  logic [AW-1:0]          clr_cnt_r;
  logic [2:0]             cnt_r;
  logic [IW-1:0]          idx_r [3];
  logic [3*CW-1:0]        corner_r [3];
  logic signed [DW-1:0]   u_r [3];
  logic signed [DW-1:0]   v_r [3];
  logic signed [PW-1:0]   prod_r, t_r;
  logic signed [XW-1:0]   cr_r [3];
  logic [IW-1:0]          vi_r;
  logic                   zr_r;

  // Memories with registered read data.
  logic [3*CW-1:0]        pos_mem [MAX_VERTICES];
  logic [3*SW-1:0]        acc_mem [MAX_VERTICES];
  logic                   pos_we, acc_we;
  logic [AW-1:0]          pos_wa, pos_ra, acc_wa, acc_ra;
  logic [3*CW-1:0]        pos_wd, pos_rd_r;
  logic [3*SW-1:0]        acc_wd, acc_rd_r;

  // Result register.
  logic                   ov_r, ov_nxt;
  mvna_pkg::nrm_res_t     ores_r;
  logic [IW-1:0]          oidx_r;
  logic                   oload;

  // Queue word fields.
  mvna_pkg::op_t          q_op;
  logic [IW-1:0]          q_ia, q_ib, q_ic;
  logic [3*CW-1:0]        q_pos;

  logic signed [DW-1:0]   ma, mb;
  logic [SW-1:0]          cx64, cy64, cz64;

  assign q_op  = mvna_pkg::op_t'(q_data[QW-1 -: mvna_pkg::OP_W]);
  assign q_ia  = q_data[QW-mvna_pkg::OP_W-1 -: IW];
  assign q_ib  = q_data[QW-mvna_pkg::OP_W-IW-1 -: IW];
  assign q_ic  = q_data[QW-mvna_pkg::OP_W-2*IW-1 -: IW];
  assign q_pos = q_data[3*CW-1:0];

  assign clr_done = (st_r != B_CLEAR);
  assign q_ready  = (st_r == B_IDLE);

  assign cx64 = {{(SW-XW){cr_r[0][XW-1]}}, cr_r[0]};
  assign cy64 = {{(SW-XW){cr_r[1][XW-1]}}, cr_r[1]};
  assign cz64 = {{(SW-XW){cr_r[2][XW-1]}}, cr_r[2]};

  // Memory port control.
  always_comb begin
    pos_we = 1'b0;
    pos_wa = AW'(q_ia);
    pos_wd = q_pos;
    pos_ra = AW'(idx_r[(cnt_r[1:0] == 2'd3) ? 2'd2 : cnt_r[1:0]]);
    acc_we = 1'b0;
    acc_wa = AW'(q_ia);
    acc_wd = '0;
    acc_ra = AW'(q_ia);
    unique case (st_r)
      B_CLEAR: begin
        acc_we = 1'b1;
        acc_wa = clr_cnt_r;
      end
      B_IDLE: begin
        if (q_valid && (q_op == mvna_pkg::OP_LOAD)) begin
          pos_we = 1'b1;
          acc_we = 1'b1;
        end
      end
      B_FACC: begin
        acc_ra = AW'(idx_r[cnt_r[2:1]]);
        acc_wa = AW'(idx_r[cnt_r[2:1]]);
        if (cnt_r[0]) begin
          acc_we = 1'b1;
          acc_wd = {mvna_pkg::sat_add64(acc_rd_r[3*SW-1:2*SW], cz64),
                    mvna_pkg::sat_add64(acc_rd_r[2*SW-1:SW], cy64),
                    mvna_pkg::sat_add64(acc_rd_r[SW-1:0], cx64)};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    pos_rd_r <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_wa] <= acc_wd;
    end
    acc_rd_r <= acc_mem[acc_ra];
  end

  // Cross product operand schedule: six products, paired into three differences.
  always_comb begin
    unique case (cnt_r)
      3'd0: begin ma = u_r[1]; mb = v_r[2]; end
      3'd1: begin ma = u_r[2]; mb = v_r[1]; end
      3'd2: begin ma = u_r[2]; mb = v_r[0]; end
      3'd3: begin ma = u_r[0]; mb = v_r[2]; end
      3'd4: begin ma = u_r[0]; mb = v_r[1]; end
      3'd5: begin ma = u_r[1]; mb = v_r[0]; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign norm_start = (st_r == B_RSTART);
  assign norm_sx    = acc_rd_r[SW-1:0];
  assign norm_sy    = acc_rd_r[2*SW-1:SW];
  assign norm_sz    = acc_rd_r[3*SW-1:2*SW];

  assign oload = (st_r == B_ROUT) && (!ov_r || out_ready);

  always_comb begin
    if (oload) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= B_CLEAR;
      clr_cnt_r <= '0;
      ov_r      <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      unique case (st_r)
        B_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == AW'(MAX_VERTICES - 1)) begin
            st_r <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (q_valid) begin
            unique case (q_op)
              mvna_pkg::OP_LOAD:  st_r <= B_IDLE;
              mvna_pkg::OP_FACE:  st_r <= B_FPOS;
              mvna_pkg::OP_READ:  st_r <= B_RSTART;
              mvna_pkg::OP_READZ: st_r <= B_ROUT;
              default:            st_r <= B_IDLE;
            endcase
          end
        end
        B_FPOS: begin
          if (cnt_r == 3'd3) begin
            st_r <= B_FDIFF;
          end
        end
        B_FDIFF: begin
          st_r <= B_FMUL;
        end
        B_FMUL: begin
          if (cnt_r == 3'd6) begin
            st_r <= B_FACC;
          end
        end
        B_FACC: begin
          if (cnt_r == 3'd5) begin
            st_r <= B_IDLE;
          end
        end
        B_RSTART: begin
          st_r <= B_RNORM;
        end
        B_RNORM: begin
          if (norm_done) begin
            st_r <= B_ROUT;
          end
        end
        B_ROUT: begin
          if (oload) begin
            st_r <= B_IDLE;
          end
        end
        default: begin
          st_r <= B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      B_IDLE: begin
        cnt_r    <= '0;
        idx_r[0] <= q_ia;
        idx_r[1] <= q_ib;
        idx_r[2] <= q_ic;
        vi_r     <= q_ia;
        zr_r     <= (q_op == mvna_pkg::OP_READZ);
      end
      B_FPOS: begin
        if (cnt_r != 3'd0) begin
          corner_r[cnt_r[1:0] - 2'd1] <= pos_rd_r;
        end
        cnt_r <= cnt_r + 3'd1;
      end
      B_FDIFF: begin
        for (int i = 0; i < 3; i++) begin
          u_r[i] <= DW'($signed(corner_r[1][i*CW +: CW])) -
                    DW'($signed(corner_r[0][i*CW +: CW]));
          v_r[i] <= DW'($signed(corner_r[2][i*CW +: CW])) -
                    DW'($signed(corner_r[0][i*CW +: CW]));
        end
        cnt_r <= '0;
      end
      B_FMUL: begin
        prod_r <= ma * mb;
        if (cnt_r != 3'd0) begin
          if (!cnt_r[0]) begin
            cr_r[2'((cnt_r - 3'd1) >> 1)] <= XW'(t_r) - XW'(prod_r);
          end else begin
            t_r <= prod_r;
          end
        end
        cnt_r <= (cnt_r == 3'd6) ? 3'd0 : cnt_r + 3'd1;
      end
      B_FACC: begin
        cnt_r <= cnt_r + 3'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (oload) begin
      oidx_r <= vi_r;
      if (zr_r) begin
        ores_r.degen <= 1'b1;
        ores_r.nx    <= '0;
        ores_r.ny    <= '0;
        ores_r.nz    <= '0;
      end else begin
        ores_r <= norm_res;
      end
    end
  end

  assign out_valid        = ov_r;
  assign out_vertex_index = oidx_r;
  assign out_normal_x     = ores_r.nx;
  assign out_normal_y     = ores_r.ny;
  assign out_normal_z     = ores_r.nz;
  assign out_degenerate   = ores_r.degen;

endmodule

/* rtl/mesh_vertex_normal_accumulator.sv */
// Top level of the area-weighted vertex normal accumulator.
// Depends on mvna_pkg and instantiates mvna_front, mvna_queue, mvna_back and mvna_norm.

// The block keeps MAX_VERTICES vertex positions and a saturating 64-bit normal sum per
// vertex. An item loads a vertex (position stored, sum cleared), adds a face (its cross
// product (B-A)x(C-A) is added to all three corners) or reads a vertex, which returns the
// sum scaled to a unit vector in signed Q1.15 with a degenerate flag for a zero sum.
// After reset the accumulator memory is swept to zero, one vertex per cycle, so the input
// is not ready until the sweep has finished. A front end takes and classifies items
// and drops those that do nothing (unused request codes, loads and faces with an index out
// of range); a two-entry queue lets it keep accepting while the back end works. The back
// end has one read and one write port on each memory and one multiplier, which set its
// cost per item: a load is one write to each memory, and a face takes three position
// reads, six products and three read-modify-writes of the accumulator memory. For a read
// of a valid vertex the cost is set by the iterative normalization unit: a
// one-bit-per-cycle alignment shift, a 32-step square root and three 16-step divisions.
// A finished result sits in an output register, so the back end goes on with loads and
// faces while it waits to be taken.
module mesh_vertex_normal_accumulator #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_BITS   = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mvna_pkg::REQ_W-1:0]        in_req_type,
  input  logic [mvna_pkg::IDX_W-1:0]        in_index_a,
  input  logic [mvna_pkg::IDX_W-1:0]        in_index_b,
  input  logic [mvna_pkg::IDX_W-1:0]        in_index_c,
  input  logic signed [COORD_BITS-1:0]      in_pos_x,
  input  logic signed [COORD_BITS-1:0]      in_pos_y,
  input  logic signed [COORD_BITS-1:0]      in_pos_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mvna_pkg::IDX_W-1:0]        out_vertex_index,
  output logic signed [mvna_pkg::NRM_W-1:0] out_normal_x,
  output logic signed [mvna_pkg::NRM_W-1:0] out_normal_y,
  output logic signed [mvna_pkg::NRM_W-1:0] out_normal_z,
  output logic                              out_degenerate
);

  // Width of one queued operation: code, three indices and a position.
  localparam int QW = mvna_pkg::OP_W + 3 * mvna_pkg::IDX_W + 3 * COORD_BITS;

  logic                        clr_done;
  logic                        f_valid, f_ready;
  logic [QW-1:0]               f_data;
  logic                        b_valid, b_ready;
  logic [QW-1:0]               b_data;
  logic                        norm_start, norm_done;
  logic [mvna_pkg::ACC_W-1:0]  norm_sx, norm_sy, norm_sz;
  mvna_pkg::nrm_res_t          norm_res;

  // Classification; held off until the clearing sweep has finished.
  mvna_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (clr_done),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_index_a  (in_index_a),
    .in_index_b  (in_index_b),
    .in_index_c  (in_index_c),
    .in_pos_x    (in_pos_x),
    .in_pos_y    (in_pos_y),
    .in_pos_z    (in_pos_z),
    .q_valid     (f_valid),
    .q_ready     (f_ready),
    .q_data      (f_data)
  );

  mvna_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_data)
  );

  // Memories, face sequencer and the result register.
  mvna_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .clr_done         (clr_done),
    .q_valid          (b_valid),
    .q_ready          (b_ready),
    .q_data           (b_data),
    .norm_start       (norm_start),
    .norm_sx          (norm_sx),
    .norm_sy          (norm_sy),
    .norm_sz          (norm_sz),
    .norm_done        (norm_done),
    .norm_res         (norm_res),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_vertex_index (out_vertex_index),
    .out_normal_x     (out_normal_x),
    .out_normal_y     (out_normal_y),
    .out_normal_z     (out_normal_z),
    .out_degenerate   (out_degenerate)
  );

  // Shared iterative shift, square root and divide.
  mvna_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .sx    (norm_sx),
    .sy    (norm_sy),
    .sz    (norm_sz),
    .done  (norm_done),
    .res   (norm_res)
  );

endmodule

/* rtl/mvna_checker.sv */
// Port-level checker for the vertex normal accumulator, bound to the top level.
// Depends on mvna_pkg for field widths; sees only the top level's ports.
module mvna_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [mvna_pkg::IDX_W-1:0]        out_vertex_index,
  input logic signed [mvna_pkg::NRM_W-1:0] out_normal_x,
  input logic signed [mvna_pkg::NRM_W-1:0] out_normal_y,
  input logic signed [mvna_pkg::NRM_W-1:0] out_normal_z,
  input logic                              out_degenerate
);

  localparam logic [mvna_pkg::NRM_W-1:0] NEG_FULL = {1'b1, {(mvna_pkg::NRM_W-1){1'b0}}};

  // A result that waits keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vertex_index) &&
      $stable(out_normal_x) && $stable(out_normal_y) && $stable(out_normal_z) &&
      $stable(out_degenerate))
    else $error("result changed while stalled");

  // A degenerate result carries a zero vector.
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0)
    else $error("degenerate result with a nonzero component");

  // Components are saturated symmetrically, so the most negative code never shows.
  a_no_neg_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_normal_x != NEG_FULL && out_normal_y != NEG_FULL &&
      out_normal_z != NEG_FULL)
    else $error("component outside the saturated range");

  // The clearing sweep starts at reset: no item taken and no result shown just after.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("block active right after reset");

endmodule

bind mesh_vertex_normal_accumulator mvna_checker u_mvna_checker (.*);

/* test/mesh_vertex_normal_accumulator_tb.sv */
// Self-checking testbench for mesh_vertex_normal_accumulator: loads, faces and normal reads.
// It predicts every read result from its own copy of the vertex table and accumulators.
// Depends on mvna_pkg and the RTL of the block.
`timescale 1ns / 1ps

module mesh_vertex_normal_accumulator_tb;

  localparam int NV = 1024;
  localparam int CB = 24;

  // One expected read result, in the order the reads were accepted.
  typedef struct {
    logic [mvna_pkg::IDX_W-1:0] vidx;
    logic [mvna_pkg::NRM_W-1:0] nx;
    logic [mvna_pkg::NRM_W-1:0] ny;
    logic [mvna_pkg::NRM_W-1:0] nz;
    logic                       degen;
  } normal_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [mvna_pkg::REQ_W-1:0] in_req_type;
  logic [mvna_pkg::IDX_W-1:0] in_index_a;
  logic [mvna_pkg::IDX_W-1:0] in_index_b;
  logic [mvna_pkg::IDX_W-1:0] in_index_c;
  logic signed [CB-1:0] in_pos_x;
  logic signed [CB-1:0] in_pos_y;
  logic signed [CB-1:0] in_pos_z;
  logic out_valid;
  logic out_ready;
  logic [mvna_pkg::IDX_W-1:0] out_vertex_index;
  logic signed [mvna_pkg::NRM_W-1:0] out_normal_x;
  logic signed [mvna_pkg::NRM_W-1:0] out_normal_y;
  logic signed [mvna_pkg::NRM_W-1:0] out_normal_z;
  logic out_degenerate;

  // The predictor's own copy of the block state.
  logic signed [CB-1:0] vert_x[NV];
  logic signed [CB-1:0] vert_y[NV];
  logic signed [CB-1:0] vert_z[NV];
  longint sum_x[NV];
  longint sum_y[NV];
  longint sum_z[NV];
  // Faces only ever touch vertices whose position has been loaded.
  bit loaded[NV];
  int loaded_list[$];

  normal_t pending_normals[$];
  int mismatches;
  bit no_idle;
  bit out_stall_on;
  // Set while in_valid is being held high by the sender.
  bit valid_up;

  mesh_vertex_normal_accumulator #(
    .MAX_VERTICES(NV),
    .COORD_BITS(CB)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_index_a(in_index_a),
    .in_index_b(in_index_b),
    .in_index_c(in_index_c),
    .in_pos_x(in_pos_x),
    .in_pos_y(in_pos_y),
    .in_pos_z(in_pos_z),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_vertex_index(out_vertex_index),
    .out_normal_x(out_normal_x),
    .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z),
    .out_degenerate(out_degenerate)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Saturating signed 64-bit add, written from the arithmetic rules.
  function automatic longint clamp_add(input longint a, input longint b);
    longint s;
    s = a + b;
    if (b > 0 && s < a) s = 64'h7fff_ffff_ffff_ffff;
    if (b < 0 && s > a) s = 64'h8000_0000_0000_0000;
    return s;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned s);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Scales an accumulated sum to a Q1.15 unit vector.
  function automatic normal_t unit_from_sum(input logic [mvna_pkg::IDX_W-1:0] vi,
                                            input longint sx, input longint sy,
                                            input longint sz);
    normal_t r;
    longint s[3];
    longint unsigned a[3];
    longint unsigned m;
    longint unsigned sq;
    longint unsigned root;
    longint unsigned q;
    logic [mvna_pkg::NRM_W-1:0] n[3];
    int p;
    s[0] = sx;
    s[1] = sy;
    s[2] = sz;
    m = 0;
    r.vidx = vi;
    for (int i = 0; i < 3; i++) begin
      a[i] = (s[i] < 0) ? (64'd0 - longint'(s[i])) : s[i];
      if (a[i] > m) m = a[i];
    end
    if (m == 0) begin
      r.nx = '0;
      r.ny = '0;
      r.nz = '0;
      r.degen = 1'b1;
      return r;
    end
    p = 0;
    while (p < 63 && (m >> (p + 1)) != 0) p++;
    // Align so the largest magnitude has its top bit at bit 29.
    for (int i = 0; i < 3; i++) begin
      if (p > 29) a[i] = a[i] >> (p - 29);
      else a[i] = a[i] << (29 - p);
    end
    sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    root = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << 15) + (root >> 1)) / root;
      if (q > 32767) q = 32767;
      n[i] = (s[i] < 0) ? (16'd0 - q[15:0]) : q[15:0];
    end
    r.nx = n[0];
    r.ny = n[1];
    r.nz = n[2];
    r.degen = 1'b0;
    return r;
  endfunction

  // Applies one accepted item to the predicted state.
  task automatic predict_item(input mvna_pkg::req_t rq, input int ia, input int ib,
                              input int ic,
                              input logic signed [CB-1:0] px,
                              input logic signed [CB-1:0] py,
                              input logic signed [CB-1:0] pz);
    longint ux, uy, uz, vx, vy, vz, cx, cy, cz;
    int corner[3];
    case (rq)
      mvna_pkg::REQ_LOAD: begin
        vert_x[ia] = px;
        vert_y[ia] = py;
        vert_z[ia] = pz;
        sum_x[ia] = 0;
        sum_y[ia] = 0;
        sum_z[ia] = 0;
        if (!loaded[ia]) begin
          loaded[ia] = 1'b1;
          loaded_list.insert(loaded_list.size(), ia);
        end
      end
      mvna_pkg::REQ_FACE: begin
        ux = longint'(vert_x[ib]) - longint'(vert_x[ia]);
        uy = longint'(vert_y[ib]) - longint'(vert_y[ia]);
        uz = longint'(vert_z[ib]) - longint'(vert_z[ia]);
        vx = longint'(vert_x[ic]) - longint'(vert_x[ia]);
        vy = longint'(vert_y[ic]) - longint'(vert_y[ia]);
        vz = longint'(vert_z[ic]) - longint'(vert_z[ia]);
        cx = uy * vz - uz * vy;
        cy = uz * vx - ux * vz;
        cz = ux * vy - uy * vx;
        corner[0] = ia;
        corner[1] = ib;
        corner[2] = ic;
        for (int k = 0; k < 3; k++) begin
          sum_x[corner[k]] = clamp_add(sum_x[corner[k]], cx);
          sum_y[corner[k]] = clamp_add(sum_y[corner[k]], cy);
          sum_z[corner[k]] = clamp_add(sum_z[corner[k]], cz);
        end
      end
      mvna_pkg::REQ_READ: begin
        pending_normals.insert(pending_normals.size(),
                               unit_from_sum(ia[mvna_pkg::IDX_W-1:0], sum_x[ia],
                                             sum_y[ia], sum_z[ia]));
      end
      default: begin
      end
    endcase
  endtask

  // Mostly short gaps, a few long ones; none at all while no_idle is set.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one item and waits until the block takes it.
  task automatic send_item(input logic [mvna_pkg::REQ_W-1:0] rq, input int ia,
                           input int ib, input int ic,
                           input logic signed [CB-1:0] px,
                           input logic signed [CB-1:0] py,
                           input logic signed [CB-1:0] pz);
    int gap;
    in_valid <= 1'b1;
    valid_up = 1'b1;
    in_req_type <= rq;
    in_index_a <= ia[mvna_pkg::IDX_W-1:0];
    in_index_b <= ib[mvna_pkg::IDX_W-1:0];
    in_index_c <= ic[mvna_pkg::IDX_W-1:0];
    in_pos_x <= px;
    in_pos_y <= py;
    in_pos_z <= pz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(mvna_pkg::req_t'(rq), ia, ib, ic, px, py, pz);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drops in_valid after the last item unless a gap has already done so.
  task automatic stop_sending();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  function automatic logic signed [CB-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return CB'($urandom_range(0, 16'hffff) - 32768);
    if (r < 9) return CB'($urandom());
    return (r[0]) ? 24'sh7fffff : -24'sh800000;
  endfunction

  function automatic int rand_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  task automatic wait_drained();
    stop_sending();
    while (pending_normals.size() != 0) @(posedge clk);
  endtask

  // Extreme positions, every request code, repeated corners and zero sums.
  task automatic test_directed();
    send_item(mvna_pkg::REQ_READ, 5, 0, 0, 0, 0, 0);
    send_item(mvna_pkg::REQ_LOAD, 0, 0, 0, 0, 0, 0);
    send_item(mvna_pkg::REQ_LOAD, 1, 1023, 1023, 24'sh7fffff, -24'sh800000, 24'sh7fffff);
    send_item(mvna_pkg::REQ_LOAD, 1023, 0, 0, -24'sh800000, 24'sh7fffff, -24'sh800000);
    send_item(mvna_pkg::REQ_LOAD, 2, 0, 0, 24'sh001000, 0, 0);
    send_item(mvna_pkg::REQ_LOAD, 3, 0, 0, 0, 24'sh001000, 0);
    send_item(mvna_pkg::REQ_READ, 1023, 0, 0, 24'sh7fffff, 0, 0);
    send_item(mvna_pkg::REQ_FACE, 0, 2, 3, 0, 0, 0);
    send_item(mvna_pkg::REQ_READ, 0, 0, 0, 0, 0, 0);
    send_item(mvna_pkg::REQ_READ, 2, 0, 0, 0, 0, 0);
    send_item(mvna_pkg::REQ_FACE, 0, 1, 1023, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
    send_item(mvna_pkg::REQ_READ, 1, 0, 0, 0, 0, 0);
    send_item(mvna_pkg::REQ_READ, 1023, 0, 0, 0, 0, 0);
    send_item(mvna_pkg::REQ_FACE, 1, 1, 3, 0, 0, 0);
    send_item(mvna_pkg::REQ_FACE, 2, 3, 2, 0, 0, 0);
    send_item(mvna_pkg::REQ_READ, 3, 1023, 1023, 0, 0, 0);
    // Unused request code: ignored, fields set to all ones.
    send_item(2'd3, 1023, 1023, 1023, -24'sd1, -24'sd1, -24'sd1);
    send_item(mvna_pkg::REQ_LOAD, 0, 0, 0, 24'sh000123, 24'sh000456, -24'sh000789);
    send_item(mvna_pkg::REQ_READ, 0, 0, 0, 0, 0, 0);
    wait_drained();
  endtask

  // Random traffic over a small working set so that sums build up before reads.
  task automatic test_random(input int count);
    int r;
    int a;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 25 || loaded_list.size() < 3) begin
        a = (loaded_list.size() > 12 && r < 15) ? rand_loaded() : $urandom_range(0, NV - 1);
        send_item(mvna_pkg::REQ_LOAD, a, $urandom_range(0, NV - 1),
                  $urandom_range(0, NV - 1), rand_coord(), rand_coord(), rand_coord());
      end else if (r < 70) begin
        send_item(mvna_pkg::REQ_FACE, rand_loaded(), rand_loaded(), rand_loaded(),
                  rand_coord(), rand_coord(), rand_coord());
      end else if (r < 96) begin
        a = (r < 92) ? rand_loaded() : $urandom_range(0, NV - 1);
        send_item(mvna_pkg::REQ_READ, a, $urandom_range(0, NV - 1),
                  $urandom_range(0, NV - 1), rand_coord(), rand_coord(), rand_coord());
      end else begin
        send_item(2'd3, $urandom_range(0, NV - 1), $urandom_range(0, NV - 1),
                  $urandom_range(0, NV - 1), rand_coord(), rand_coord(), rand_coord());
      end
    end
  endtask

  // The sender holds off until every outstanding read has returned.
  task automatic test_drain_pause();
    test_random(20);
    wait_drained();
    @(posedge clk);
    test_random(20);
  endtask

  // Back-to-back items with the receiver always ready.
  task automatic test_no_idle();
    no_idle = 1'b1;
    out_stall_on = 1'b0;
    test_random(150);
    no_idle = 1'b0;
    out_stall_on = 1'b1;
  endtask

  // Result side: random stalls, mostly short, a few long.
  initial begin
    int hold;
    out_ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!out_stall_on) begin
        out_ready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 30) begin
        hold = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 60);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compares every accepted result with the oldest expected normal.
  always @(posedge clk) begin
    normal_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: vertex %0d", out_vertex_index);
      end else begin
        e = pending_normals.pop_front();
        if (out_vertex_index !== e.vidx || out_normal_x !== e.nx ||
            out_normal_y !== e.ny || out_normal_z !== e.nz ||
            out_degenerate !== e.degen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected v%0d (%0d %0d %0d) d%0b, got v%0d (%0d %0d %0d) d%0b",
                     e.vidx, $signed(e.nx), $signed(e.ny), $signed(e.nz), e.degen,
                     out_vertex_index, out_normal_x, out_normal_y, out_normal_z,
                     out_degenerate);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("mesh_vertex_normal_accumulator test failed");
    $finish;
  end

  initial begin
    mismatches = 0;
    no_idle = 1'b0;
    out_stall_on = 1'b1;
    valid_up = 1'b0;
    for (int i = 0; i < NV; i++) begin
      vert_x[i] = '0;
      vert_y[i] = '0;
      vert_z[i] = '0;
      sum_x[i] = 0;
      sum_y[i] = 0;
      sum_z[i] = 0;
      loaded[i] = 1'b0;
    end
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = '0;
    in_index_a = '0;
    in_index_b = '0;
    in_index_c = '0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(700);
    test_drain_pause();
    test_no_idle();
    test_random(800);
    wait_drained();
    repeat (300) @(posedge clk);
    if (mismatches == 0 && pending_normals.size() == 0) begin
      $display("mesh_vertex_normal_accumulator test passed");
    end else begin
      $display("mesh_vertex_normal_accumulator test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/mvna_pkg.sv
rtl/mvna_front.sv
rtl/mvna_queue.sv
rtl/mvna_norm.sv
rtl/mvna_back.sv
rtl/mesh_vertex_normal_accumulator.sv
rtl/mvna_checker.sv
test/mesh_vertex_normal_accumulator_tb.sv
